// ===== sv/socl_pkg.sv =====
// Shared widths and the controller-to-datapath command and status types.
package socl_pkg;

  localparam int unsigned SIDE_W = 11;   // grid side and coordinate width
  localparam int unsigned POS_W  = 24;   // spiral position width
  localparam int unsigned AREA_W = 22;   // product of two sides
  localparam int unsigned CNT_W  = 13;   // cells in one ring
  localparam int unsigned SUM_W  = 14;   // coordinate arithmetic width

  typedef struct packed {
    logic load;         // capture the request fields
    logic calc_total;   // register columns times rows
    logic init_ring;    // set up the outer ring and the offset
    logic peel;         // drop the current ring, step inward
    logic pick_side;    // register which side holds the offset
    logic write_found;  // load the result register with the cell
    logic write_miss;   // load the result register with not found
  } socl_cmd_t;

  typedef struct packed {
    logic miss;         // empty grid or position past the last cell
    logic in_ring;      // offset lies inside the current ring
    logic out_busy;     // result register holds a result not taken now
  } socl_sts_t;

endpackage

// ===== sv/socl_in_if.sv =====
// Request channel: grid size and spiral position with valid/ready.
interface socl_in_if;
  logic                          valid;
  logic                          ready;
  logic [socl_pkg::SIDE_W-1:0]   grid_columns;
  logic [socl_pkg::SIDE_W-1:0]   grid_rows;
  logic [socl_pkg::POS_W-1:0]    position;

  modport source (output valid, output grid_columns, output grid_rows, output position,
                  input ready);
  modport sink   (input valid, input grid_columns, input grid_rows, input position,
                  output ready);
endinterface

// ===== sv/socl_out_if.sv =====
// Result channel: found flag and 1-based cell coordinates with valid/ready.
interface socl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [socl_pkg::SIDE_W-1:0]   column;
  logic [socl_pkg::SIDE_W-1:0]   row;

  modport source (output valid, output found, output column, output row, input ready);
  modport sink   (input valid, input found, input column, input row, output ready);
endinterface

// ===== sv/socl_ctrl.sv =====
// Sequencer for the spiral locator: accept, size check, ring peeling, result write.
module socl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  socl_pkg::socl_sts_t sts,
  output socl_pkg::socl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_PEEL  = 3'd3;
  localparam logic [2:0] ST_SIDE  = 3'd4;
  localparam logic [2:0] ST_COORD = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.calc_total = 1'b1;
        state_nxt      = ST_CHK;
      end
      ST_CHK: begin
        if (sts.miss) begin
          if (!sts.out_busy) begin
            cmd.write_miss = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.init_ring = 1'b1;
          state_nxt     = ST_PEEL;
        end
      end
      ST_PEEL: begin
        if (sts.in_ring) begin
          state_nxt = ST_SIDE;
        end else begin
          cmd.peel = 1'b1;
        end
      end
      ST_SIDE: begin
        cmd.pick_side = 1'b1;
        state_nxt     = ST_COORD;
      end
      ST_COORD: begin
        if (!sts.out_busy) begin
          cmd.write_found = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a result write always returns to idle on the next edge
  a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_found || cmd.write_miss) |=> (state_r == ST_IDLE))
    else $error("result written without returning to idle");

  // while idle nothing but a capture may be issued
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.peel || cmd.write_found || cmd.write_miss || cmd.pick_side))
    else $error("work command issued while idle");

endmodule

// ===== sv/socl_dp.sv =====
// Datapath: request registers, ring bounds, offset, side select and result register.
module socl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  socl_pkg::socl_cmd_t               cmd,
  output socl_pkg::socl_sts_t               sts,
  input  logic [socl_pkg::SIDE_W-1:0]       in_grid_columns,
  input  logic [socl_pkg::SIDE_W-1:0]       in_grid_rows,
  input  logic [socl_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [socl_pkg::SIDE_W-1:0]       out_column,
  output logic [socl_pkg::SIDE_W-1:0]       out_row
);

  localparam int unsigned SW = socl_pkg::SIDE_W;
  localparam int unsigned KW = socl_pkg::AREA_W;
  localparam int unsigned CW = socl_pkg::CNT_W;
  localparam int unsigned XW = socl_pkg::SUM_W;

  localparam logic [1:0] SIDE_LOW_COL  = 2'd0;  // walking up the rows
  localparam logic [1:0] SIDE_HIGH_ROW = 2'd1;  // walking up the columns
  localparam logic [1:0] SIDE_HIGH_COL = 2'd2;  // walking down the rows
  localparam logic [1:0] SIDE_LOW_ROW  = 2'd3;  // walking down the columns

  logic [SW-1:0]                  cols_r, rows_r;
  logic [socl_pkg::POS_W-1:0]     pos_r;
  logic [socl_pkg::AREA_W-1:0]    total_r;
  logic [KW-1:0]                  k_r;
  logic [SW-1:0]                  h_r, w_r, lo_r;
  logic [1:0]                     side_r;
  logic                           out_valid_r, out_found_r;
  logic [SW-1:0]                  out_col_r, out_row_r;

  logic [socl_pkg::POS_W-1:0]     pos_m1;
  logic [SW:0]                    hw_sum;
  logic [CW-1:0]                  ring_cnt;
  logic [CW-1:0]                  t1, t2, t3, kk;
  logic [1:0]                     side_nxt;
  logic [XW-1:0]                  lo_x, h_x, w_x, k_x, col_x, row_x;

  assign pos_m1 = pos_r - socl_pkg::POS_W'(1);
  assign hw_sum = {1'b0, h_r} + {1'b0, w_r};

  // a single row or column ring holds h*w cells, which is h+w-1 there
  assign ring_cnt = (h_r == SW'(1) || w_r == SW'(1)) ?
                    ({1'b0, hw_sum} - CW'(1)) : ({hw_sum, 1'b0} - CW'(4));

  assign sts.miss     = (cols_r == '0) || (rows_r == '0) ||
                        (pos_r > {{(socl_pkg::POS_W-socl_pkg::AREA_W){1'b0}}, total_r});
  assign sts.in_ring  = (k_r < {{(KW-CW){1'b0}}, ring_cnt});
  assign sts.out_busy = out_valid_r && !out_ready;

  // side boundaries inside the final ring; the offset fits CW bits there
  assign kk = k_r[CW-1:0];
  assign t1 = {2'b00, h_r};
  assign t2 = {1'b0, hw_sum} - CW'(1);
  assign t3 = {1'b0, hw_sum} + {2'b00, h_r} - CW'(2);

  always_comb begin
    if (kk < t1) begin
      side_nxt = SIDE_LOW_COL;
    end else if (kk < t2) begin
      side_nxt = SIDE_HIGH_ROW;
    end else if (kk < t3) begin
      side_nxt = SIDE_HIGH_COL;
    end else begin
      side_nxt = SIDE_LOW_ROW;
    end
  end

  // 1-based coordinates straight from bounds and offset
  assign lo_x = XW'(lo_r);
  assign h_x  = XW'(h_r);
  assign w_x  = XW'(w_r);
  assign k_x  = XW'(kk);

  always_comb begin
    case (side_r)
      SIDE_LOW_COL: begin
        col_x = lo_x + XW'(1);
        row_x = lo_x + k_x + XW'(1);
      end
      SIDE_HIGH_ROW: begin
        col_x = lo_x + k_x + XW'(2) - h_x;
        row_x = lo_x + h_x;
      end
      SIDE_HIGH_COL: begin
        col_x = lo_x + w_x;
        row_x = lo_x + (h_x << 1) + w_x - XW'(2) - k_x;
      end
      default: begin
        col_x = lo_x + (w_x << 1) + (h_x << 1) - XW'(3) - k_x;
        row_x = lo_x + XW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cols_r <= in_grid_columns;
      rows_r <= in_grid_rows;
      pos_r  <= in_position;
    end
    if (cmd.calc_total) begin
      total_r <= {{SW{1'b0}}, cols_r} * {{SW{1'b0}}, rows_r};
    end
    if (cmd.init_ring) begin
      k_r  <= (pos_r == '0) ? '0 : pos_m1[KW-1:0];
      h_r  <= rows_r;
      w_r  <= cols_r;
      lo_r <= '0;
    end else if (cmd.peel) begin
      k_r  <= k_r - {{(KW-CW){1'b0}}, ring_cnt};
      h_r  <= h_r - SW'(2);
      w_r  <= w_r - SW'(2);
      lo_r <= lo_r + SW'(1);
    end
    if (cmd.pick_side) begin
      side_r <= side_nxt;
    end
    if (cmd.write_found) begin
      out_found_r <= 1'b1;
      out_col_r   <= col_x[SW-1:0];
      out_row_r   <= row_x[SW-1:0];
    end else if (cmd.write_miss) begin
      out_found_r <= 1'b0;
      out_col_r   <= '0;
      out_row_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write_found || cmd.write_miss) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_column = out_col_r;
  assign out_row    = out_row_r;

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_found || cmd.write_miss) |-> !sts.out_busy)
    else $error("result register overwritten");

  // a ring is only peeled while an inner ring remains
  a_peel_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.peel |-> (h_r > SW'(2) && w_r > SW'(2)))
    else $error("peeled past the innermost ring");

  // found cells have nonzero coordinates, misses have zero ones
  a_coord_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r ? (out_col_r != '0 && out_row_r != '0)
                                 : (out_col_r == '0 && out_row_r == '0)))
    else $error("coordinates disagree with found flag");

endmodule

// ===== sv/spiral_order_cell_locator_top.sv =====
// Top level of the spiral-order cell locator: sequencer plus datapath.
//
// Usage: each request on in_chan carries grid_columns, grid_rows and a
// 1-based position. One result leaves on out_chan per request: found, and
// the 1-based column and row of the cell reached at that position of a
// spiral walk that starts at column 1, row 1 and first runs down column 1.
// A position past rows*columns, or an empty grid, gives found 0 with zero
// coordinates; position zero is taken as position one.
// in_chan.ready is high only while the block is idle, so one request is
// worked at a time. After acceptance the sizes are multiplied and checked;
// a miss is then written to the result register. Otherwise R whole rings
// are peeled before the position's ring (R at most (min(rows, columns) - 1)/2,
// 511 for 1024 sides), one ring per cycle through a single 22-bit subtract
// and compare; then the side is picked and the cell is written.
// in_chan.ready rises again in the cycle after the result write.
// The result register parts the two channels: the next request is taken
// while a result waits, and a stalled receiver only holds the block once
// the following result is ready to be written.
// Reset (rst_n low, synchronous) idles the sequencer and empties the result register.
module spiral_order_cell_locator_top (
  input  logic      clk,
  input  logic      rst_n,
  socl_in_if.sink   in_chan,
  socl_out_if.source out_chan
);

  socl_pkg::socl_cmd_t cmd;
  socl_pkg::socl_sts_t sts;
  logic                in_ready;

  // sequencer: owns the request handshake and steps the datapath
  socl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  // datapath: ring bounds, offset and the result register
  socl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_grid_columns (in_chan.grid_columns),
    .in_grid_rows    (in_chan.grid_rows),
    .in_position     (in_chan.position),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_found       (out_chan.found),
    .out_column      (out_chan.column),
    .out_row         (out_chan.row)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the spiral-order cell locator: random and directed requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_W = socl_pkg::SIDE_W;
  localparam int unsigned POS_W  = socl_pkg::POS_W;

  // One request as it goes onto the input channel.
  typedef struct packed {
    logic [SIDE_W-1:0] grid_columns;
    logic [SIDE_W-1:0] grid_rows;
    logic [POS_W-1:0]  position;
  } spiral_req_t;

  // One result as the block should deliver it.
  typedef struct packed {
    logic              found;
    logic [SIDE_W-1:0] column;
    logic [SIDE_W-1:0] row;
  } cell_t;

  // A pending result, kept with the request that caused it for the log.
  typedef struct packed {
    spiral_req_t req;
    cell_t       want;
  } cell_due_t;

  logic clk;
  logic rst_n;

  socl_in_if  in_bus ();
  socl_out_if out_bus ();

  spiral_order_cell_locator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  spiral_req_t requests_pending[$];  // filled by the stimulus block, drained by the driver
  cell_due_t   cells_due[$];         // expected results, oldest first
  int unsigned mismatches = 0;

  spiral_req_t in_flight;            // request currently offered on in_bus
  cell_due_t   due_sent;             // expected result built by the driver
  cell_due_t   due;                  // expected result taken by the monitor
  int unsigned send_gap;
  bit          send_steady = 1'b0;
  int unsigned take_hold;
  bit          take_steady = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Work out the cell at a spiral position. Peel whole rings off the grid
  // until the zero-based offset falls inside the current ring, then walk
  // the four sides of that ring: down the low column, along the high row,
  // back up the high column, then along the low row.
  function automatic cell_t locate_cell(spiral_req_t req);
    int unsigned cols, rows, pos, total, k;
    int unsigned lo_r, hi_r, lo_c, hi_c, h, w, ring_cells, r, c;
    cell_t spot;
    cols = req.grid_columns;
    rows = req.grid_rows;
    pos  = req.position;
    spot = '0;
    total = cols * rows;
    // Empty grids and positions past the last cell report not found.
    if (cols == 0 || rows == 0 || pos > total) return spot;
    // Position zero lands on the first cell.
    k = (pos == 0) ? 0 : pos - 1;
    lo_r = 0; hi_r = rows - 1;
    lo_c = 0; hi_c = cols - 1;
    h = rows;
    w = cols;
    ring_cells = (h == 1 || w == 1) ? h * w : 2 * (h + w) - 4;
    while (k >= ring_cells) begin
      k -= ring_cells;
      lo_r++; hi_r--;
      lo_c++; hi_c--;
      h = hi_r - lo_r + 1;
      w = hi_c - lo_c + 1;
      ring_cells = (h == 1 || w == 1) ? h * w : 2 * (h + w) - 4;
    end
    if (k < h) begin
      c = lo_c;
      r = lo_r + k;
    end else if (k < h + w - 1) begin
      r = hi_r;
      c = lo_c + (k - h) + 1;
    end else if (k < 2 * h + w - 2) begin
      c = hi_c;
      r = hi_r - (k - (h + w - 1)) - 1;
    end else begin
      r = lo_r;
      c = hi_c - (k - (2 * h + w - 2)) - 1;
    end
    spot.found  = 1'b1;
    spot.column = SIDE_W'(c + 1);
    spot.row    = SIDE_W'(r + 1);
    return spot;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string msg);
    $display("tb_top: mismatch: %s", msg);
    mismatches++;
  endtask

  // Mostly small sides so that ring peeling stays short; now and then a
  // large one, and rarely a side past the nominal maximum up to all ones.
  function automatic logic [SIDE_W-1:0] draw_side();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SIDE_W'($urandom_range(1, 32));
    if (pick < 90) return SIDE_W'($urandom_range(1, 256));
    if (pick < 97) return SIDE_W'($urandom_range(1, 1024));
    return SIDE_W'($urandom_range(1, 2047));
  endfunction

  function automatic spiral_req_t draw_request();
    spiral_req_t req;
    int unsigned pick, total, back;
    req.grid_columns = draw_side();
    req.grid_rows    = draw_side();
    total = req.grid_columns * req.grid_rows;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // anywhere inside the grid
      req.position = POS_W'($urandom_range(1, total));
    end else if (pick < 75) begin
      // near the end of the walk: one of the last nine cells, deep in the spiral
      back = (total - 1 < 8) ? total - 1 : 8;
      req.position = POS_W'(total - $urandom_range(0, back));
    end else if (pick < 85) begin
      // just past the last cell
      req.position = POS_W'(total + $urandom_range(1, 1000));
    end else if (pick < 90) begin
      req.position = '0;
    end else if (pick < 95) begin
      // full-width position, mostly a miss; sets the top bits
      req.position = POS_W'($urandom_range(0, 24'hFFFFFF));
    end else begin
      // empty grid on one or both sides
      if ($urandom_range(0, 1)) req.grid_columns = '0;
      else req.grid_rows = '0;
      if ($urandom_range(0, 3) == 0) begin
        req.grid_columns = '0;
        req.grid_rows    = '0;
      end
      req.position = POS_W'($urandom_range(0, 24'hFFFFFF));
    end
    return req;
  endfunction

  function automatic spiral_req_t make_request(int unsigned cols, int unsigned rows,
                                               int unsigned pos);
    spiral_req_t req;
    req.grid_columns = SIDE_W'(cols);
    req.grid_rows    = SIDE_W'(rows);
    req.position     = POS_W'(pos);
    return req;
  endfunction

  // Request driver: offer the next request once the previous one is taken
  // and its idle gap has run out. Gaps come in random stretches, with
  // stretches of back-to-back requests in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid        <= 1'b0;
      in_bus.grid_columns <= '0;
      in_bus.grid_rows    <= '0;
      in_bus.position     <= '0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        due_sent.req  = in_flight;
        due_sent.want = locate_cell(in_flight);
        cells_due.push_back(due_sent);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          in_flight = requests_pending.pop_front();
          in_bus.grid_columns <= in_flight.grid_columns;
          in_bus.grid_rows    <= in_flight.grid_rows;
          in_bus.position     <= in_flight.position;
          in_bus.valid        <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : $urandom_range(0, 5);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest expected
  // one, field by field, then hold ready low for a random stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      take_hold = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (cells_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0d column=%0d row=%0d",
                                    out_bus.found, out_bus.column, out_bus.row));
        end else begin
          due = cells_due.pop_front();
          if (out_bus.found !== due.want.found)
            report_mismatch($sformatf("%0dx%0d pos %0d: found %0d, want %0d",
                                      due.req.grid_columns, due.req.grid_rows,
                                      due.req.position, out_bus.found, due.want.found));
          if (out_bus.column !== due.want.column)
            report_mismatch($sformatf("%0dx%0d pos %0d: column %0d, want %0d",
                                      due.req.grid_columns, due.req.grid_rows,
                                      due.req.position, out_bus.column, due.want.column));
          if (out_bus.row !== due.want.row)
            report_mismatch($sformatf("%0dx%0d pos %0d: row %0d, want %0d",
                                      due.req.grid_columns, due.req.grid_rows,
                                      due.req.position, out_bus.row, due.want.row));
        end
        if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
        take_hold = take_steady ? 0 : $urandom_range(0, 5);
      end else if (take_hold > 0) begin
        take_hold--;
      end
      out_bus.ready <= (take_hold == 0);
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_n = 1'b0;

    // Directed requests: tiny and huge grids, misses, empty grids,
    // position zero, single rows and columns, each side of a ring.
    requests_pending.push_back(make_request(1, 1, 1));
    requests_pending.push_back(make_request(1, 1, 2));              // past the grid
    requests_pending.push_back(make_request(5, 4, 0));              // position zero
    requests_pending.push_back(make_request(0, 5, 1));              // no columns
    requests_pending.push_back(make_request(5, 0, 1));              // no rows
    requests_pending.push_back(make_request(0, 0, 0));
    requests_pending.push_back(make_request(7, 1, 5));              // single row
    requests_pending.push_back(make_request(1, 9, 6));              // single column
    requests_pending.push_back(make_request(6, 5, 3));              // low column
    requests_pending.push_back(make_request(6, 5, 8));              // high row
    requests_pending.push_back(make_request(6, 5, 12));             // high column
    requests_pending.push_back(make_request(6, 5, 16));             // low row
    requests_pending.push_back(make_request(6, 5, 20));             // inner ring
    requests_pending.push_back(make_request(4, 7, 28));             // last cell, even by odd
    requests_pending.push_back(make_request(1024, 1024, 1));
    requests_pending.push_back(make_request(1024, 1024, 1048576));  // center cell
    requests_pending.push_back(make_request(1024, 1024, 1048577));  // one past the end
    requests_pending.push_back(make_request(1024, 1024, 24'hFFFFFF));
    requests_pending.push_back(make_request(2047, 2047, 1));
    requests_pending.push_back(make_request(2047, 2047, 2047 * 2047));
    requests_pending.push_back(make_request(2047, 1, 2047));
    requests_pending.push_back(make_request(1, 2047, 2047));
    requests_pending.push_back(make_request(2047, 2047, 24'hFFFFFF));

    repeat (1150) requests_pending.push_back(draw_request());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait on the falling edge so the queues are stable.
    do @(negedge clk);
    while (requests_pending.size() != 0 || in_bus.valid || cells_due.size() != 0);

    // Allow time for any stray result to show up.
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #100ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
